FILE: sv/udcc_pkg.sv
// Shared types and constants for the utf-8 distinct code point counter.
// No dependencies; imported by every module of the block.
package udcc_pkg;

  // fixed field widths of the stream ports
  localparam int BYTE_W  = 8;
  localparam int CODE_W  = 21;
  localparam int COUNT_W = 22;

  // default sizing of the seen bitmap
  localparam int POINT_BITS_DEF    = 21;
  localparam int MAP_WORD_BITS_DEF = 64;

  // decoded-item queue between the front and back ends
  localparam int QUEUE_DEPTH = 4;

  // byte classification masks
  localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_CODE  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD2_DATA  = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_CODE  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_DATA  = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_CODE  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_DATA  = 8'h07;
  localparam logic [BYTE_W-1:0] CONT_MASK   = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_CODE   = 8'h80;
  localparam logic [BYTE_W-1:0] CONT_DATA   = 8'h3F;

  // one decoded byte: whether it finished a code point, and the point
  typedef struct packed {
    logic              done;
    logic [CODE_W-1:0] cp;
  } item_t;

endpackage

FILE: sv/utf8_distinct_codepoint_counter.sv
// Top level of the utf-8 distinct code point counter.
// Depends on udcc_pkg, udcc_front, udcc_queue and udcc_bitmap.
//
// Takes one utf-8 byte per transfer and returns one result per byte: whether
// the byte finished a code point, the point, whether it is new, and the
// running number of distinct points. The block sustains one byte per clock
// while m_tready stays high and the bitmap is not being cleared; each byte
// passes through the decoupling queue and the registered read of the
// seen-bitmap memory, which then loads the result register (one read and one
// write port per cycle). A stalled output fills the result register, the
// lookup stage and the four-entry queue before s_tready drops.
// After reset, s_tready stays low while the bitmap memory, 2^(POINT_BITS -
// floor(log2 MAP_WORD_BITS)) words (32768 with the defaults), is swept to
// zero one word per cycle.
module utf8_distinct_codepoint_counter #(
  parameter int POINT_BITS    = udcc_pkg::POINT_BITS_DEF,
  parameter int MAP_WORD_BITS = udcc_pkg::MAP_WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // byte_value
  input  logic        s_tlast,   // end_of_buffer
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // code_point [20:0], distinct_total [42:21], zero fill
  output logic [1:0]  m_tuser    // point_done [0], first_seen [1]
);
  import udcc_pkg::*;

  item_t               dec_item;
  item_t               q_item;
  logic                dec_push;
  logic                q_ready;
  logic                q_valid;
  logic                q_pop;
  logic                clearing;
  logic                point_done;
  logic [CODE_W-1:0]   code_point;
  logic                first_seen;
  logic [COUNT_W-1:0]  distinct_total;

  // byte decoder
  udcc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_ready  (q_ready),
    .clearing (clearing),
    .push     (dec_push),
    .item     (dec_item)
  );

  // decoupling queue
  udcc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (dec_push),
    .push_item (dec_item),
    .in_ready  (q_ready),
    .pop       (q_pop),
    .out_valid (q_valid),
    .out_item  (q_item)
  );

  // bitmap update and result register
  udcc_bitmap #(
    .POINT_BITS    (POINT_BITS),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_bitmap (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (q_valid),
    .in_item        (q_item),
    .pop            (q_pop),
    .clearing       (clearing),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .point_done     (point_done),
    .code_point     (code_point),
    .first_seen     (first_seen),
    .distinct_total (distinct_total)
  );

  // result packing
  assign m_tdata = {5'd0, distinct_total, code_point};
  assign m_tuser = {first_seen, point_done};

endmodule

FILE: sv/udcc_front.sv
// Front end: utf-8 byte decoder that turns each accepted byte into one item.
// Depends on udcc_pkg.
module udcc_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [udcc_pkg::BYTE_W-1:0] s_tdata,  // byte_value
  input  logic                       s_tlast,  // end_of_buffer
  input  logic                       q_ready,
  input  logic                       clearing,
  output logic                       push,
  output udcc_pkg::item_t            item
);
  import udcc_pkg::*;

  logic [1:0]        pending;
  logic [CODE_W-1:0] accum;
  logic              good;
  logic [1:0]        pending_next;
  logic [CODE_W-1:0] accum_next;
  logic              good_next;
  logic [BYTE_W-1:0] b;

  assign s_tready = q_ready && !clearing;
  assign push     = s_tvalid && s_tready;
  assign b        = s_tdata;

  // decode one byte against the open sequence
  always_comb begin
    pending_next = pending;
    accum_next   = accum;
    good_next    = good;
    item.done    = 1'b0;
    item.cp      = '0;
    if (pending == 2'd0) begin
      priority if (b < ASCII_LIMIT) begin
        item.done = 1'b1;
        item.cp   = CODE_W'(b);
      end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
        pending_next = 2'd1;
        accum_next   = CODE_W'(b & LEAD2_DATA);
        good_next    = 1'b1;
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
        pending_next = 2'd2;
        accum_next   = CODE_W'(b & LEAD3_DATA);
        good_next    = 1'b1;
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
        pending_next = 2'd3;
        accum_next   = CODE_W'(b & LEAD4_DATA);
        good_next    = 1'b1;
      end else begin
        // stray continuation or f8-ff: skipped
        pending_next = pending;
      end
    end else begin
      good_next    = good && ((b & CONT_MASK) == CONT_CODE);
      accum_next   = {accum[CODE_W-7:0], b[5:0]};
      pending_next = pending - 2'd1;
      if (pending_next == 2'd0) begin
        item.done  = good_next;
        item.cp    = good_next ? accum_next : '0;
        accum_next = '0;
        good_next  = 1'b1;
      end
    end
    // end of buffer drops whatever is still open
    if (s_tlast && pending_next != 2'd0) begin
      pending_next = 2'd0;
      accum_next   = '0;
      good_next    = 1'b1;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
      accum   <= '0;
      good    <= 1'b1;
    end else if (push) begin
      pending <= pending_next;
      accum   <= accum_next;
      good    <= good_next;
    end
  end

endmodule

FILE: sv/udcc_queue.sv
// Short queue of decoded items between the decoder and the bitmap stage.
// Depends on udcc_pkg.
module udcc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  udcc_pkg::item_t push_item,
  output logic            in_ready,
  input  logic            pop,
  output logic            out_valid,
  output udcc_pkg::item_t out_item
);
  import udcc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_pop;

  assign in_ready  = count != CNT_W'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_item  = slots[rd_ptr];
  assign do_pop    = pop && out_valid;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/udcc_bitmap.sv
// Back end: seen-bitmap memory with read-modify-write, distinct count and result register.
// Depends on udcc_pkg.
module udcc_bitmap #(
  parameter int POINT_BITS    = udcc_pkg::POINT_BITS_DEF,
  parameter int MAP_WORD_BITS = udcc_pkg::MAP_WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  udcc_pkg::item_t             in_item,
  output logic                        pop,
  output logic                        clearing,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        point_done,
  output logic [udcc_pkg::CODE_W-1:0]  code_point,
  output logic                        first_seen,
  output logic [udcc_pkg::COUNT_W-1:0] distinct_total
);
  import udcc_pkg::*;

  // physical word is the largest power of two that fits the requested word
  localparam int WORD_LOG  = $clog2(MAP_WORD_BITS + 1) - 1;
  localparam int WORD_BITS = 1 << WORD_LOG;
  localparam int ADDR_W    = POINT_BITS - WORD_LOG;
  localparam int DEPTH     = 1 << ADDR_W;
  localparam logic [CODE_W-1:0] POINT_MASK = {CODE_W{1'b1}} >> (CODE_W - POINT_BITS);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_data;
  logic [ADDR_W-1:0]    clr_addr;

  logic                 s1_valid;
  item_t                s1_item;
  logic                 s1_adv;
  logic                 issue;
  logic [CODE_W-1:0]    in_cp;
  logic [ADDR_W-1:0]    in_word;
  logic [ADDR_W-1:0]    s1_word;
  logic [WORD_LOG-1:0]  s1_bit;

  logic                 wr_valid;
  logic [ADDR_W-1:0]    wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  logic [WORD_BITS-1:0] merged;
  logic [WORD_BITS-1:0] set_word;
  logic                 is_new;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   count_next;

  // pipeline control
  assign s1_adv  = s1_valid && (!out_valid || out_ready);
  assign issue   = in_valid && !clearing && (!s1_valid || s1_adv);
  assign pop     = issue;
  assign in_cp   = in_item.cp & POINT_MASK;
  assign in_word = in_cp[POINT_BITS-1:WORD_LOG];
  assign s1_word = s1_item.cp[POINT_BITS-1:WORD_LOG];
  assign s1_bit  = s1_item.cp[WORD_LOG-1:0];

  // forward the last write, which the registered read may have missed
  assign merged     = (wr_valid && wr_addr == s1_word) ? wr_data : rd_data;
  assign is_new     = s1_item.done && !merged[s1_bit];
  assign set_word   = merged | (WORD_BITS'(1) << s1_bit);
  assign count_next = count + COUNT_W'(is_new);

  // write port: clearing sweep or bit set
  assign mem_we    = clearing || (s1_adv && is_new);
  assign mem_waddr = clearing ? clr_addr : s1_word;
  assign mem_wdata = clearing ? '0 : set_word;

  // bitmap memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_data <= mem[in_word];
    end
  end

  // lookup stage payload
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_item.done <= in_item.done;
      s1_item.cp   <= in_cp;
    end
    if (s1_adv && is_new) begin
      wr_addr <= s1_word;
      wr_data <= set_word;
    end
    if (s1_adv) begin
      point_done     <= s1_item.done;
      code_point     <= s1_item.cp;
      first_seen     <= is_new;
      distinct_total <= count_next;
    end
  end

  // control state: clear sweep, stage valids, count
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      s1_valid  <= 1'b0;
      wr_valid  <= 1'b0;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (&clr_addr) begin
          clearing <= 1'b0;
        end
      end
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv && is_new) begin
        wr_valid <= 1'b1;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
        count     <= count_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
